// File: hw/rtl/ufp_pkg.sv
package ufp_pkg;

    localparam int MAX_FIELD = 1024;
    localparam int CNT_W     = $clog2(MAX_FIELD + 1);

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_PAIR  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR   = 3'd1;
    localparam logic [2:0] ERR_EQUALS     = 3'd2;
    localparam logic [2:0] ERR_AMPERSAND  = 3'd3;
    localparam logic [2:0] ERR_NAME_ESC   = 3'd4;
    localparam logic [2:0] ERR_VALUE_ESC  = 3'd5;
    localparam logic [2:0] ERR_EMPTY_END  = 3'd6;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd7;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CTRL_HI = 8'h1f;
    localparam logic [7:0] CH_DEL     = 8'h7f;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FIELD);

    typedef struct packed {
        logic             in_value_part;
        logic [1:0]       escape_step;
        logic [3:0]       high_nibble;
        logic [CNT_W-1:0] name_count;
        logic [CNT_W-1:0] value_count;
        logic             halted;
    } ufp_state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] code;
    } ufp_result_t;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] h;
        begin
            h = 5'd16;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                h = 5'(c - 8'h30);
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                h = 5'(c - 8'h57);
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                h = 5'(c - 8'h37);
            end
            return h;
        end
    endfunction

endpackage

// File: hw/rtl/ufp_step.sv
module ufp_step import ufp_pkg::*; (
    input  logic [7:0]  in_byte,
    input  logic        end_of_data,
    input  ufp_state_t  st,
    output ufp_state_t  st_next,
    output ufp_result_t res
);

    logic [CNT_W-1:0] cnt;
    logic [4:0]       hex;
    logic [2:0]       esc_err;
    logic [1:0]       kind;

    assign cnt     = st.in_value_part ? st.value_count : st.name_count;
    assign hex     = hex_value(in_byte);
    assign esc_err = st.in_value_part ? ERR_VALUE_ESC : ERR_NAME_ESC;
    assign kind    = st.in_value_part ? KIND_VALUE : KIND_NAME;

    always_comb
    begin
        st_next = st;
        res     = '0;
        if (st.halted)
        begin
            st_next = st;
        end
        else if (end_of_data)
        begin
            if (!st.in_value_part)
            begin
                st_next        = '0;
            end
            else if (st.value_count == '0)
            begin
                st_next.halted = 1'b1;
                res            = '{1'b1, KIND_ERROR, 8'h00, ERR_EMPTY_END};
            end
            else if (st.escape_step != ESC_NONE)
            begin
                st_next.halted = 1'b1;
                res            = '{1'b1, KIND_ERROR, 8'h00, ERR_VALUE_ESC};
            end
            else
            begin
                st_next        = '0;
                res            = '{1'b1, KIND_PAIR, 8'h00, ERR_NONE};
            end
        end
        else if (in_byte <= CH_CTRL_HI || in_byte >= CH_DEL)
        begin
            st_next.halted = 1'b1;
            res            = '{1'b1, KIND_ERROR, 8'h00, ERR_BAD_CHAR};
        end
        else if (in_byte == CH_EQUALS)
        begin
            if (st.in_value_part)
            begin
                st_next.halted = 1'b1;
                res            = '{1'b1, KIND_ERROR, 8'h00, ERR_EQUALS};
            end
            else if (st.escape_step != ESC_NONE)
            begin
                st_next.halted = 1'b1;
                res            = '{1'b1, KIND_ERROR, 8'h00, ERR_NAME_ESC};
            end
            else
            begin
                st_next.in_value_part = 1'b1;
            end
        end
        else if (in_byte == CH_AMP)
        begin
            if (!st.in_value_part)
            begin
                st_next.halted = 1'b1;
                res            = '{1'b1, KIND_ERROR, 8'h00, ERR_AMPERSAND};
            end
            else if (st.escape_step != ESC_NONE)
            begin
                st_next.halted = 1'b1;
                res            = '{1'b1, KIND_ERROR, 8'h00, ERR_VALUE_ESC};
            end
            else
            begin
                st_next = '0;
                res     = '{1'b1, KIND_PAIR, 8'h00, ERR_NONE};
            end
        end
        else if (cnt >= CNT_MAX)
        begin
            st_next.halted = 1'b1;
            res            = '{1'b1, KIND_ERROR, 8'h00, ERR_TOO_LONG};
        end
        else
        begin
            if (st.in_value_part)
            begin
                st_next.value_count = st.value_count + 1'b1;
            end
            else
            begin
                st_next.name_count = st.name_count + 1'b1;
            end
            if (st.escape_step == ESC_HIGH || st.escape_step == ESC_LOW)
            begin
                if (hex[4])
                begin
                    st_next.halted = 1'b1;
                    res            = '{1'b1, KIND_ERROR, 8'h00, esc_err};
                end
                else if (st.escape_step == ESC_HIGH)
                begin
                    st_next.high_nibble = hex[3:0];
                    st_next.escape_step = ESC_LOW;
                end
                else
                begin
                    st_next.escape_step = ESC_NONE;
                    res = '{1'b1, kind, {st.high_nibble, hex[3:0]}, ERR_NONE};
                end
            end
            else if (in_byte == CH_PERCENT)
            begin
                st_next.escape_step = ESC_HIGH;
            end
            else if (in_byte == CH_PLUS)
            begin
                res = '{1'b1, kind, CH_SPACE, ERR_NONE};
            end
            else
            begin
                res = '{1'b1, kind, in_byte, ERR_NONE};
            end
        end
    end

endmodule

// File: hw/rtl/urlencoded_form_parser.sv
// Decodes an url-encoded form body one byte per item: '+' gives a space, '%'
// and two hex digits give one byte, '&' or an end marker closes a pair. Emits
// at most one result per item (name byte, value byte, pair complete, or an
// error, after which it halts until reset). Takes one item every cycle while
// the output is not stalled; an item is held in the input registers, passes
// the single state update stage and lands in the result register.
module urlencoded_form_parser import ufp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] out_byte,
    output logic [2:0] error_code
);

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    ufp_state_t  state_reg;
    ufp_state_t  state_next;
    ufp_result_t res_next;
    ufp_result_t out_reg;
    logic        advance;

    ufp_step u_step (
        .in_byte     (byte_reg),
        .end_of_data (end_reg),
        .st          (state_reg),
        .st_next     (state_next),
        .res         (res_next)
    );

    assign advance  = !out_reg.valid || out_ready;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            out_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_reg.valid <= in_valid_reg && res_next.valid;
                if (in_valid_reg)
                begin
                    state_reg     <= state_next;
                    out_reg.kind  <= res_next.kind;
                    out_reg.data  <= res_next.data;
                    out_reg.code  <= res_next.code;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            end_reg  <= end_of_data;
        end
    end

    assign out_valid   = out_reg.valid;
    assign result_kind = out_reg.kind;
    assign out_byte    = out_reg.data;
    assign error_code  = out_reg.code;

endmodule

// File: tb/tb_urlencoded_form_parser.sv
module tb_urlencoded_form_parser import ufp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 500;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] code;
    } form_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       end_of_data;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;

    form_result_t pending_results[$];
    form_result_t head_result;
    int           fail_count;
    int           items_sent;
    int           idle_cycles;
    int           hold_cycles;
    int           stall_left;
    bit           sender_idle_en;
    bit           receiver_stall_en;

    // decoder shadow state
    bit         dec_in_value;
    logic [1:0] dec_esc;
    logic [3:0] dec_high;
    int         dec_name_len;
    int         dec_value_len;
    bit         dec_halted;

    urlencoded_form_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_data (end_of_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .out_byte    (out_byte),
        .error_code  (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return 5'(c - "0");
        end
        if (c >= "a" && c <= "f")
        begin
            return 5'(c - "a" + 10);
        end
        if (c >= "A" && c <= "F")
        begin
            return 5'(c - "A" + 10);
        end
        return 5'd16;
    endfunction

    function automatic void queue_result(input logic [1:0] kind, input logic [7:0] data,
                                         input logic [2:0] code);
        form_result_t r;
        r.kind = kind;
        r.data = data;
        r.code = code;
        pending_results.push_back(r);
    endfunction

    function automatic void clear_pair();
        dec_in_value  = 1'b0;
        dec_esc       = ESC_NONE;
        dec_high      = 4'd0;
        dec_name_len  = 0;
        dec_value_len = 0;
    endfunction

    function automatic void halt_with(input logic [2:0] code);
        dec_halted = 1'b1;
        queue_result(KIND_ERROR, 8'h00, code);
    endfunction

    function automatic void decode_item(input logic [7:0] c, input logic last);
        logic [1:0] kind;
        logic [2:0] esc_err;
        logic [4:0] h;
        int         field_len;
        if (dec_halted)
        begin
            return;
        end
        if (last)
        begin
            if (!dec_in_value)
            begin
                clear_pair();
            end
            else if (dec_value_len == 0)
            begin
                halt_with(ERR_EMPTY_END);
            end
            else if (dec_esc != ESC_NONE)
            begin
                halt_with(ERR_VALUE_ESC);
            end
            else
            begin
                clear_pair();
                queue_result(KIND_PAIR, 8'h00, ERR_NONE);
            end
            return;
        end
        if (c <= CH_CTRL_HI || c >= CH_DEL)
        begin
            halt_with(ERR_BAD_CHAR);
            return;
        end
        if (c == CH_EQUALS)
        begin
            if (dec_in_value)
            begin
                halt_with(ERR_EQUALS);
            end
            else if (dec_esc != ESC_NONE)
            begin
                halt_with(ERR_NAME_ESC);
            end
            else
            begin
                dec_in_value = 1'b1;
            end
            return;
        end
        if (c == CH_AMP)
        begin
            if (!dec_in_value)
            begin
                halt_with(ERR_AMPERSAND);
            end
            else if (dec_esc != ESC_NONE)
            begin
                halt_with(ERR_VALUE_ESC);
            end
            else
            begin
                clear_pair();
                queue_result(KIND_PAIR, 8'h00, ERR_NONE);
            end
            return;
        end
        kind      = dec_in_value ? KIND_VALUE : KIND_NAME;
        esc_err   = dec_in_value ? ERR_VALUE_ESC : ERR_NAME_ESC;
        field_len = dec_in_value ? dec_value_len : dec_name_len;
        if (field_len >= MAX_FIELD)
        begin
            halt_with(ERR_TOO_LONG);
            return;
        end
        if (dec_in_value)
        begin
            dec_value_len++;
        end
        else
        begin
            dec_name_len++;
        end
        if (dec_esc != ESC_NONE)
        begin
            h = hex_digit(c);
            if (h[4])
            begin
                halt_with(esc_err);
            end
            else if (dec_esc == ESC_HIGH)
            begin
                dec_high = h[3:0];
                dec_esc  = ESC_LOW;
            end
            else
            begin
                dec_esc = ESC_NONE;
                queue_result(kind, {dec_high, h[3:0]}, ERR_NONE);
            end
            return;
        end
        if (c == CH_PERCENT)
        begin
            dec_esc = ESC_HIGH;
            return;
        end
        queue_result(kind, (c == CH_PLUS) ? CH_SPACE : c, ERR_NONE);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 75)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    task automatic send_item(input logic [7:0] c, input logic last);
        int gap;
        gap = 0;
        if (sender_idle_en && $urandom_range(0, 2) == 0)
        begin
            gap = gap_len();
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        in_byte     <= c;
        end_of_data <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        decode_item(c, last);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            send_item(s[i], 1'b0);
        end
    endtask

    // in_byte is don't-care with the end marker
    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] pick_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return 8'("0" + v);
        end
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    function automatic logic [7:0] pick_plain_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(8'h20, 8'h7e));
        end
        while (c == CH_EQUALS || c == CH_AMP || c == CH_PERCENT);
        return c;
    endfunction

    task automatic send_field_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            send_item(CH_PERCENT, 1'b0);
            send_item(pick_hex_char(), 1'b0);
            send_item(pick_hex_char(), 1'b0);
        end
        else if (r == 2)
        begin
            send_item(CH_PLUS, 1'b0);
        end
        else
        begin
            send_item(pick_plain_char(), 1'b0);
        end
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        sender_idle_en    = 1'b0;
        receiver_stall_en = 1'b0;
        send_text("a+b=%41%7e&");
        send_text("=&");
        send_text(" =~");
        send_end();
        send_text("n%4");
        send_end();
        send_end();
        wait_drain();
    endtask

    task automatic test_max_field();
        int i;
        sender_idle_en    = 1'b1;
        receiver_stall_en = 1'b1;
        for (i = 0; i < MAX_FIELD; i++)
        begin
            send_item(pick_plain_char(), 1'b0);
        end
        send_item(CH_EQUALS, 1'b0);
        for (i = 0; i < MAX_FIELD; i++)
        begin
            send_item(pick_plain_char(), 1'b0);
        end
        send_item(CH_AMP, 1'b0);
        wait_drain();
    endtask

    task automatic test_backpressure();
        int i;
        sender_idle_en    = 1'b0;
        receiver_stall_en = 1'b0;
        hold_cycles = 300;
        for (i = 0; i < 40; i++)
        begin
            send_field_char();
        end
        send_text("=v&");
        wait_drain();
    endtask

    task automatic send_random_pair();
        int name_len;
        int value_len;
        int i;
        name_len = $urandom_range(0, 6);
        for (i = 0; i < name_len; i++)
        begin
            send_field_char();
        end
        if ($urandom_range(0, 9) == 0)
        begin
            // name dropped at end, possibly with an open escape
            if ($urandom_range(0, 1))
            begin
                send_item(CH_PERCENT, 1'b0);
                if ($urandom_range(0, 1))
                begin
                    send_item(pick_hex_char(), 1'b0);
                end
            end
            send_end();
            return;
        end
        send_item(CH_EQUALS, 1'b0);
        value_len = $urandom_range(0, 6);
        for (i = 0; i < value_len; i++)
        begin
            send_field_char();
        end
        if (value_len == 0 || $urandom_range(0, 3) != 0)
        begin
            send_item(CH_AMP, 1'b0);
        end
        else
        begin
            send_end();
        end
    endtask

    task automatic test_random_pairs();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                sender_idle_en    = $urandom_range(0, 1);
                receiver_stall_en = $urandom_range(0, 1);
            end
            send_random_pair();
        end
        wait_drain();
    endtask

    task automatic test_error_halt();
        logic [2:0] code;
        int         i;
        sender_idle_en    = 1'b1;
        receiver_stall_en = 1'b1;
        code = 3'($urandom_range(1, 7));
        unique case (code)
            ERR_BAD_CHAR:
            begin
                send_text("ab");
                if ($urandom_range(0, 1))
                begin
                    send_item(8'($urandom_range(8'h00, CH_CTRL_HI)), 1'b0);
                end
                else
                begin
                    send_item(8'($urandom_range(CH_DEL, 8'hff)), 1'b0);
                end
            end
            ERR_EQUALS:
            begin
                send_text("a=b=");
            end
            ERR_AMPERSAND:
            begin
                send_text("ab&");
            end
            ERR_NAME_ESC:
            begin
                if ($urandom_range(0, 1))
                begin
                    send_text("n%4=");
                end
                else
                begin
                    send_text("n%g");
                end
            end
            ERR_VALUE_ESC:
            begin
                unique case ($urandom_range(0, 2))
                    0: send_text("a=%4&");
                    1: send_text("a=%x");
                    default:
                    begin
                        send_text("a=%");
                        send_end();
                    end
                endcase
            end
            ERR_EMPTY_END:
            begin
                send_text("a=");
                send_end();
            end
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    send_item(CH_EQUALS, 1'b0);
                end
                for (i = 0; i <= MAX_FIELD; i++)
                begin
                    send_item(pick_plain_char(), 1'b0);
                end
            end
        endcase
        // halted: anything goes, nothing comes out
        for (i = 0; i < 24; i++)
        begin
            send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        in_byte           = 8'h00;
        end_of_data       = 1'b0;
        fail_count        = 0;
        items_sent        = 0;
        hold_cycles       = 0;
        sender_idle_en    = 1'b0;
        receiver_stall_en = 1'b0;
        dec_halted        = 1'b0;
        clear_pair();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_max_field();
        test_backpressure();
        test_random_pairs();
        test_error_halt();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (receiver_stall_en && $urandom_range(0, 3) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = gap_len() - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d byte %02h code %0d",
                       result_kind, out_byte, error_code);
                fail_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (result_kind !== head_result.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", head_result.kind, result_kind);
                    fail_count++;
                end
                if (out_byte !== head_result.data)
                begin
                    $error("out_byte: expected %02h, got %02h", head_result.data, out_byte);
                    fail_count++;
                end
                if (error_code !== head_result.code)
                begin
                    $error("error_code: expected %0d, got %0d", head_result.code, error_code);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $error("no item moved for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
